>>> design/stream_find_replace_assert.svh
// Assertion macros used by the checker file of the stream find and replace block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find and replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int LEN_W     = 4;
  localparam int TOTAL_W   = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BYTES       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPL
  } sfr_state_t;

  // Commands that the sequencer sends to every cell of the window.
  typedef struct packed {
    logic load;   // append the new text byte at the first free cell
    logic shift;  // move every byte one cell toward the head
    logic clear;  // empty the window
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// Text byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> design/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_out_if;
  import sfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               has_byte;
  logic               out_last;
  logic [TOTAL_W-1:0] match_total;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  output match_total, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input out_last,
                  input match_total, output ready);
endinterface

`default_nettype wire

>>> design/sfr_cfg_if.sv
// ----------------------------------------------------------------------------
// sfr_cfg_if
// Configuration write channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_cfg_if;
  import sfr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One byte of the pending window: holds a byte, takes its right neighbor's
// byte on a shift and compares itself with its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell import sfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [BYTE_W-1:0] new_byte,
  input  wire logic [BYTE_W-1:0] pat_byte,
  input  wire logic              left_valid,
  input  wire logic              right_valid,
  input  wire logic [BYTE_W-1:0] right_byte,
  output logic [BYTE_W-1:0]      cell_byte,
  output logic                   cell_valid,
  output logic                   hit
);

  logic load_here;

  // The new byte lands in the first empty cell after the occupied ones.
  assign load_here = ctrl.load && !cell_valid && left_valid;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      cell_valid <= 1'b0;
    end else if (ctrl.shift) begin
      cell_valid <= right_valid;
    end else if (load_here) begin
      cell_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cell_byte <= right_byte;
    end else if (load_here) begin
      cell_byte <= new_byte;
    end
  end

  // An empty cell never breaks the prefix test.
  assign hit = !cell_valid || (cell_byte == pat_byte);

endmodule

`default_nettype wire

>>> design/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: a released byte is registered in the window and then in the result
// register; a replacement byte also passes the REPL state. The input stays closed while a
// request is worked on, through each released byte and each replacement byte of a match.
// Result stalls hold the sequencer; at most one result moves per cycle.
// Reset is synchronous on rst: empties the window, clears the counter, loads default config.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace import sfr_pkg::*; #(
  parameter int SEARCH_MAX  = 8,
  parameter int REPLACE_MAX = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  sfr_in_if.sink     text,
  sfr_out_if.source  result,
  sfr_cfg_if.sink    cfg
);

  // Width of the replacement byte index; at least one bit.
  localparam int RI_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken at any time; the user is to use the
  // port only while the block is idle, which the block itself does not enforce. A new
  // pattern or pattern length empties the pending window without emitting its bytes.
  // --------------------------------------------------------------------------
  logic [CFG_DAT_W-1:0] search_bytes;
  logic [LEN_W-1:0]     search_length;
  logic [CFG_DAT_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]     replacement_length;
  logic                 cfg_write;
  logic                 cfg_pattern_write;

  assign cfg.ready         = 1'b1;
  assign cfg_write         = cfg.valid && cfg.ready;
  assign cfg_pattern_write = cfg_write &&
                             (cfg.index == CFG_SEARCH_BYTES || cfg.index == CFG_SEARCH_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      search_bytes       <= '0;
      search_length      <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (cfg.index)
        CFG_SEARCH_BYTES:       search_bytes       <= cfg.data;
        CFG_SEARCH_LENGTH:      search_length      <= cfg.data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg.data;
        CFG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths outside the supported range are clamped: a pattern of zero bytes
  // acts as one byte, and both lengths stop at the size of the hardware.
  logic [LEN_W-1:0] search_len_eff;
  logic [LEN_W-1:0] repl_len_eff;

  always_comb begin
    if (search_length == '0) begin
      search_len_eff = LEN_W'(1);
    end else if (search_length > LEN_W'(SEARCH_MAX)) begin
      search_len_eff = LEN_W'(SEARCH_MAX);
    end else begin
      search_len_eff = search_length;
    end
  end

  always_comb begin
    if (replacement_length > LEN_W'(REPLACE_MAX)) begin
      repl_len_eff = LEN_W'(REPLACE_MAX);
    end else begin
      repl_len_eff = replacement_length;
    end
  end

  // --------------------------------------------------------------------------
  // Pending window: a row of cells. Cell 0 holds the oldest pending byte.
  // Occupied cells are always contiguous from cell 0, so the valid bits also
  // encode the fill level. Between requests the window is a proper prefix of
  // the pattern; the new byte is appended behind it.
  // --------------------------------------------------------------------------
  cell_ctrl_t              cell_ctrl;
  logic                    cell_shift;
  logic                    cell_clear;
  logic [SEARCH_MAX-1:0]   cell_valid;
  logic [SEARCH_MAX-1:0]   cell_hit;
  logic [SEARCH_MAX-1:0]   at_len;
  logic [SEARCH_MAX:0]     left_vec;
  logic [SEARCH_MAX:0]     right_vec;
  logic [BYTE_W-1:0]       chain_byte [SEARCH_MAX+1];
  logic                    text_accept;

  assign text_accept     = text.valid && text.ready;
  assign cell_ctrl.load  = text_accept;
  assign cell_ctrl.shift = cell_shift;
  assign cell_ctrl.clear = cell_clear || cfg_pattern_write;

  assign left_vec              = {cell_valid, 1'b1};
  assign right_vec             = {1'b0, cell_valid};
  assign chain_byte[SEARCH_MAX] = '0;

  for (genvar gi = 0; gi < SEARCH_MAX; gi++) begin : g_cell
    sfr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .new_byte    (text.in_byte),
      .pat_byte    (search_bytes[gi*BYTE_W +: BYTE_W]),
      .left_valid  (left_vec[gi]),
      .right_valid (right_vec[gi+1]),
      .right_byte  (chain_byte[gi+1]),
      .cell_byte   (chain_byte[gi]),
      .cell_valid  (cell_valid[gi]),
      .hit         (cell_hit[gi])
    );

    assign at_len[gi] = (search_len_eff == LEN_W'(gi + 1));
  end

  // Window status seen by the sequencer.
  logic all_match;   // occupied cells spell a prefix of the pattern
  logic full;        // fill level equals the pattern length
  logic nonempty;
  logic single;      // exactly one byte pending

  assign all_match = &cell_hit;
  assign full      = |(cell_valid & at_len);
  assign nonempty  = cell_valid[0];
  assign single    = (cell_valid == SEARCH_MAX'(1));

  // --------------------------------------------------------------------------
  // Sequencer. IDLE takes one request. SCAN looks at the window once per
  // cycle: a full match is swapped for the replacement, otherwise the oldest
  // byte is released while the window is not a prefix (or while a final
  // request flushes it). REPL streams out the replacement bytes.
  // --------------------------------------------------------------------------
  sfr_state_t         state;
  sfr_state_t         state_next;
  logic               last_q;     // current request carries in_last
  logic               emitted;    // current request has produced a result
  logic [RI_W-1:0]    rep_idx;
  logic               rep_last;
  logic [BYTE_W-1:0]  rep_byte;
  logic [TOTAL_W-1:0] replace_counter;

  logic               slot_free;
  logic               do_replace;
  logic               do_release;

  logic               emit;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_has;
  logic               emit_last;
  logic               cnt_inc;
  logic               cnt_clear;

  assign slot_free  = !result.valid || result.ready;
  assign do_replace = full && all_match;
  assign do_release = !all_match || (last_q && nonempty);
  assign rep_last   = (LEN_W'(rep_idx) + LEN_W'(1) == repl_len_eff);
  assign rep_byte   = replacement_bytes[{rep_idx, 3'b000} +: BYTE_W];

  assign text.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (text_accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (do_replace) begin
          // With an empty replacement the window is now empty and SCAN
          // goes on to finish the request.
          state_next = (repl_len_eff != '0) ? S_REPL : S_SCAN;
        end else if (do_release) begin
          state_next = S_SCAN;
        end else if (!last_q || emitted || slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_REPL: begin
        if (slot_free && rep_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    emit_byte  = '0;
    emit_has   = 1'b0;
    emit_last  = 1'b0;
    cell_shift = 1'b0;
    cell_clear = 1'b0;
    cnt_inc    = 1'b0;
    cnt_clear  = 1'b0;
    case (state)
      S_SCAN: begin
        if (do_replace) begin
          cell_clear = 1'b1;
          cnt_inc    = 1'b1;
        end else if (do_release) begin
          if (slot_free) begin
            emit       = 1'b1;
            emit_byte  = chain_byte[0];
            emit_has   = 1'b1;
            emit_last  = last_q && single;
            cell_shift = 1'b1;
            cnt_clear  = last_q && single;
          end
        end else if (last_q && !emitted && slot_free) begin
          // A final request that produced nothing still closes the text
          // with one empty result.
          emit      = 1'b1;
          emit_last = 1'b1;
          cnt_clear = 1'b1;
        end
      end
      S_REPL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rep_byte;
          emit_has  = 1'b1;
          emit_last = last_q && rep_last;
          cnt_clear = last_q && rep_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_q  <= 1'b0;
      emitted <= 1'b0;
      rep_idx <= '0;
    end else if (text_accept) begin
      last_q  <= text.in_last;
      emitted <= 1'b0;
      rep_idx <= '0;
    end else if (emit) begin
      emitted <= 1'b1;
      if (state == S_REPL) begin
        rep_idx <= rep_idx + RI_W'(1);
      end
    end
  end

  // Replacement count of the current text; it saturates and is cleared as
  // the final result of the text is handed to the result register.
  always_ff @(posedge clk) begin
    if (rst || cnt_clear) begin
      replace_counter <= '0;
    end else if (cnt_inc && (replace_counter != '1)) begin
      replace_counter <= replace_counter + TOTAL_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It decouples the two sides: the block can take the next
  // request while a result still waits here.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte    <= emit_byte;
      result.has_byte    <= emit_has;
      result.out_last    <= emit_last;
      result.match_total <= replace_counter;
    end
  end

endmodule

`default_nettype wire

>>> design/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the stream find and replace block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_find_replace_assert.svh"

module sfr_checker import sfr_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [BYTE_W-1:0]  out_byte,
  input wire logic               has_byte,
  input wire logic               out_last,
  input wire logic [TOTAL_W-1:0] match_total
);

  // An empty result only ever closes a text, and carries a zero byte.
  `SFR_ASSERT_SAME(a_empty_is_final, out_valid && !has_byte, out_last && out_byte == '0, "empty result not final")

  // A request is worked on alone: the input stays closed right after one.
  `SFR_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "input open after a request")

  // A stalled result holds its payload.
  `SFR_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(has_byte) && $stable(out_last) && $stable(match_total), "stalled result changed")

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (text.valid),
  .in_ready    (text.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_byte    (result.out_byte),
  .has_byte    (result.has_byte),
  .out_last    (result.out_last),
  .match_total (result.match_total)
);

`default_nettype wire
